>>> rtl/sre_pkg.sv
// sre_pkg: shared types, request and status codes for the sequence range update engine
// no dependencies
package sre_pkg;
    localparam int CAPACITY_DEF = 1024;

    typedef enum logic [2:0] {
        REQ_ADD = 3'd0, REQ_MIN = 3'd1, REQ_INS = 3'd2,
        REQ_DEL = 3'd3, REQ_REV = 3'd4, REQ_ROT = 3'd5
    } t_req;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [10:0]        first_pos;
        logic [9:0]         last_pos;
        logic signed [31:0] operand_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic [1:0]         status;
        logic [10:0]        length;
    } t_out;
endpackage

>>> rtl/sre_ram.sv
// sre_ram: generic single-port synchronous ram, one write or read per cycle
// registered read data, no dependencies
module sre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> rtl/sre_mod.sv
// sre_mod: sequential remainder of a 32-bit amount by an LW-bit range length
// one quotient bit per cycle; depends on nothing
module sre_mod #(
    parameter int LW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_num,
    input  logic [LW-1:0] i_den,
    output logic          o_done,
    output logic [LW-1:0] o_rem
);
    logic [31:0] r_num;
    logic [LW:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [LW:0] n_try;

    assign n_try = {r_rem[LW-1:0], r_num[31]};
    assign o_rem = r_rem[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_rem  <= '0;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_num <= {r_num[30:0], 1'b0};
                r_rem <= (n_try >= {1'b0, i_den}) ? n_try - {1'b0, i_den} : n_try;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

>>> rtl/sequence_range_update_engine_top.sv
// sequence_range_update_engine_top: ordered sequence store with range requests
// uses sre_pkg, sre_ram, sre_mod
//
// the sequence lives in one single-port ram of CAPACITY words; every request is
// a walk of read/modify/write steps over that port, each element touched being
// read and, for all requests but min, written back. add walks its range once; min
// reads its range; insert and delete shift the tail one slot; reverse swaps pairs
// from both ends (two reads, then two writes per pair); revolve first takes the
// amount modulo the range length in a bit-serial remainder unit (a start step,
// the 32 quotient bits, then a finish step), then performs three reversals.
// one request is worked at a time; the result sits in an output register and the
// next request is taken as soon as that register is empty or being drained. the
// store needs no clearing: only entries below the count are ever read
module sequence_range_update_engine_top
    import sre_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sre_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output sre_pkg::t_out o_data
);
    localparam int AW = $clog2(CAPACITY);
    // counters and positions never narrower than the 11-bit first_pos request field
    localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_WR    = 7'b0000100,
        S_RD2   = 7'b0001000,
        S_SWAP  = 7'b0010000,
        S_MOD   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    t_in    r_req;
    logic [CW-1:0] r_count, r_lo, r_hi, r_end, r_k;
    logic [1:0]    r_phase;   // revolve reversal pass
    logic [31:0]   r_min, r_hold;
    logic          r_first;
    logic          r_ovalid;
    logic          r_mstart;
    t_out          r_out;

    logic          we;
    logic [AW-1:0] addr;
    logic [AW-1:0] rd_addr;
    logic [31:0]   wdata, rdata;
    logic          mod_start, mod_done;
    logic [CW-1:0] mod_rem;

    sre_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    sre_mod #(.LW(CW)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start),
        .i_num(r_req.operand_value), .i_den(r_hi - r_lo + CW'(1)),
        .o_done(mod_done), .o_rem(mod_rem)
    );

    logic take;
    assign o_stall = !(r_state == S_IDLE) || (r_ovalid && i_stall);
    assign take    = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    logic [CW-1:0] in_first, in_last;
    assign in_first = CW'(i_data.first_pos);
    assign in_last  = CW'(i_data.last_pos);

    // ram read address in S_RD depends on request
    // reads: add/min/reverse/revolve at lo, ins at hi-1, del at lo+1
    always_comb begin
        unique case (r_req.req_type) inside
            REQ_INS: rd_addr = AW'(r_hi - CW'(1));
            REQ_DEL: rd_addr = AW'(r_lo + CW'(1));
            default: rd_addr = r_lo[AW-1:0];
        endcase
    end

    // memory port drive
    always_comb begin
        we = 1'b0; addr = r_lo[AW-1:0]; wdata = r_hold;
        mod_start = r_mstart;
        unique case (r_state)
            S_RD: begin
                addr = rd_addr;
            end
            S_RD2: begin
                addr = r_hi[AW-1:0];
            end
            S_WR: begin
                we = 1'b1;
                unique case (r_req.req_type) inside
                    REQ_ADD: begin addr = r_lo[AW-1:0]; wdata = rdata + r_req.operand_value; end
                    REQ_INS: begin addr = r_hi[AW-1:0]; wdata = rdata; end
                    REQ_DEL: begin addr = r_lo[AW-1:0]; wdata = rdata; end
                    default: begin we = 1'b0; end
                endcase
            end
            S_SWAP: begin
                // first cycle: write lo with hi data, hold lo data was captured
                we = 1'b1;
                addr = r_first ? r_lo[AW-1:0] : r_hi[AW-1:0];
                wdata = r_first ? rdata : r_hold;
            end
            S_FIN: begin
                we = (r_req.req_type == REQ_INS);
                addr = r_lo[AW-1:0];
                wdata = r_req.operand_value;
            end
            default: ;
        endcase
    end

    // controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (take) begin
                    r_req   <= i_data;
                    r_min   <= '0;
                    r_first <= 1'b1;
                    r_phase <= 2'd0;
                    r_out.min_value <= '0;
                    r_out.status    <= ST_DONE;
                    r_out.length    <= 11'(r_count);
                    unique case (i_data.req_type) inside
                        REQ_ADD, REQ_REV, REQ_ROT, REQ_MIN: begin
                            r_lo <= in_first; r_hi <= in_last;
                            if (in_first > in_last || in_last >= r_count) begin
                                if (i_data.req_type == REQ_MIN || !(in_first > in_last))
                                    r_out.status <= ST_RANGE;
                                r_ovalid <= 1'b1;
                            end else if (i_data.req_type == REQ_REV) begin
                                if (in_first < in_last) r_state <= S_RD;
                                else r_ovalid <= 1'b1;
                            end else if (i_data.req_type == REQ_ROT) begin
                                if (in_first == in_last || i_data.operand_value < 0)
                                    r_ovalid <= 1'b1;
                                else begin
                                    r_state <= S_MOD; r_mstart <= 1'b1;
                                end
                            end else r_state <= S_RD;
                        end
                        REQ_INS: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                r_out.status <= ST_FULL; r_ovalid <= 1'b1;
                            end else if (in_first > r_count) begin
                                r_out.status <= ST_RANGE; r_ovalid <= 1'b1;
                            end else begin
                                r_lo <= in_first; r_hi <= r_count;
                                r_state <= (in_first == r_count) ? S_FIN : S_RD;
                            end
                        end
                        REQ_DEL: begin
                            if (r_count == '0) begin
                                r_out.status <= ST_EMPTY; r_ovalid <= 1'b1;
                            end else if (in_first >= r_count) begin
                                r_out.status <= ST_RANGE; r_ovalid <= 1'b1;
                            end else begin
                                r_lo <= in_first; r_hi <= r_count - CW'(1);
                                r_state <= (in_first + CW'(1) >= r_count) ? S_FIN : S_RD;
                            end
                        end
                        default: r_ovalid <= 1'b1;
                    endcase
                end
                S_MOD: if (mod_done) begin
                    if (mod_rem == '0) begin
                        r_state <= S_IDLE; r_ovalid <= 1'b1;
                    end else begin
                        r_k <= mod_rem; r_end <= r_hi; r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // reads: add/min at lo, ins at hi-1, del at lo+1
                    if (r_req.req_type == REQ_REV || r_req.req_type == REQ_ROT)
                        r_state <= S_RD2;
                    else r_state <= S_WR;
                end
                S_RD2: begin
                    r_hold  <= rdata;   // lo value
                    r_first <= 1'b1;
                    r_state <= S_SWAP;
                end
                S_SWAP: begin
                    if (r_first) r_first <= 1'b0;
                    else begin
                        r_first <= 1'b1;
                        if (r_lo + CW'(1) < r_hi - CW'(1)) begin
                            r_lo <= r_lo + CW'(1); r_hi <= r_hi - CW'(1);
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_WR: begin
                    unique case (r_req.req_type) inside
                        REQ_ADD, REQ_MIN: begin
                            if (r_req.req_type == REQ_MIN &&
                                (r_first || $signed(rdata) < $signed(r_min)))
                                r_min <= rdata;
                            r_first <= 1'b0;
                            if (r_lo == r_hi) r_state <= S_FIN;
                            else begin r_lo <= r_lo + CW'(1); r_state <= S_RD; end
                        end
                        REQ_INS: begin
                            r_hi <= r_hi - CW'(1);
                            r_state <= (r_hi - CW'(1) == r_lo) ? S_FIN : S_RD;
                        end
                        default: begin
                            r_lo <= r_lo + CW'(1);
                            r_state <= (r_lo + CW'(2) > r_hi) ? S_FIN : S_RD;
                        end
                    endcase
                end
                S_FIN: begin
                    if (r_req.req_type == REQ_ROT && r_phase != 2'd2) begin
                        // next reversal of the three
                        r_phase <= r_phase + 2'd1;
                        r_state <= S_IDLE;
                        if (r_phase == 2'd0) begin
                            r_lo <= CW'(r_req.first_pos);
                            r_hi <= CW'(r_req.first_pos) + r_k - CW'(1);
                            r_state <= (r_k > CW'(1)) ? S_RD : S_FIN;
                        end else begin
                            r_lo <= CW'(r_req.first_pos) + r_k;
                            r_hi <= r_end;
                            r_state <= (CW'(r_req.first_pos) + r_k < r_end) ? S_RD : S_FIN;
                        end
                    end else begin
                        if (r_req.req_type == REQ_INS) begin
                            r_count <= r_count + CW'(1);
                            r_out.length <= 11'(r_count + CW'(1));
                        end else if (r_req.req_type == REQ_DEL) begin
                            r_count <= r_count - CW'(1);
                            r_out.length <= 11'(r_count - CW'(1));
                        end
                        if (r_req.req_type == REQ_MIN) r_out.min_value <= r_min;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/sre_checker.sv
// sre_checker: port-level assertions for sequence_range_update_engine_top
// uses sre_pkg; bound to the top level below
module sre_checker
    import sre_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input sre_pkg::t_out o_data,
    input logic          o_valid,
    input logic          i_stall
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed under stall");
    // min value only on a done status
    a_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_DONE |-> o_data.min_value == '0)
        else $error("min value on failed request");
    // no new transfer while a result waits stalled
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("accept while result stalled");
endmodule

bind sequence_range_update_engine_top sre_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_data(o_data), .o_valid(o_valid), .i_stall(i_stall)
);

>>> dv/tb_sequence_range_update_engine_top.sv
// tb_sequence_range_update_engine_top: self-checking bench for the sequence range update engine
// depends on sre_pkg and sequence_range_update_engine_top; the expected results come from
// a flat array model of the stored sequence kept inside the bench
module tb_sequence_range_update_engine_top;
    import sre_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int STALL_LIMIT = 200000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_in   i_data;
    logic  o_valid;
    logic  i_stall;
    t_out  o_data;

    sequence_range_update_engine_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // 10 unit period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shadow copy of the sequence
    logic [31:0] seq_mem [CAP];
    int unsigned seq_len;

    // results still owed by the block
    t_out pending_results [$];

    int err_count;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic flip_span(input int unsigned lo, input int unsigned hi);
        logic [31:0] t;
        while (lo < hi) begin
            t = seq_mem[lo];
            seq_mem[lo] = seq_mem[hi];
            seq_mem[hi] = t;
            lo++;
            hi--;
        end
    endtask

    // apply one request to the shadow sequence and return what the block must answer
    task automatic apply_request(input t_in req, output t_out res);
        int unsigned first;
        int unsigned last;
        int unsigned span;
        int unsigned k;
        logic signed [31:0] mn;
        first = req.first_pos;
        last = req.last_pos;
        res.min_value = '0;
        res.status = ST_DONE;
        case (req.req_type)
            REQ_ADD, REQ_REV, REQ_ROT: begin
                if (first <= last) begin
                    if (last >= seq_len) begin
                        res.status = ST_RANGE;
                    end else if (req.req_type == REQ_ADD) begin
                        for (int unsigned i = first; i <= last; i++)
                            seq_mem[i] = seq_mem[i] + req.operand_value;
                    end else if (req.req_type == REQ_REV) begin
                        flip_span(first, last);
                    end else begin
                        span = last - first + 1;
                        // negative amounts and single elements leave the span alone
                        if (span >= 2 && req.operand_value >= 0) begin
                            k = int'(req.operand_value) % span;
                            if (k != 0) begin
                                flip_span(first, last);
                                flip_span(first, first + k - 1);
                                flip_span(first + k, last);
                            end
                        end
                    end
                end
            end
            REQ_MIN: begin
                if (first > last || last >= seq_len) begin
                    res.status = ST_RANGE;
                end else begin
                    mn = seq_mem[first];
                    for (int unsigned i = first + 1; i <= last; i++)
                        if ($signed(seq_mem[i]) < mn) mn = seq_mem[i];
                    res.min_value = mn;
                end
            end
            REQ_INS: begin
                if (seq_len >= CAP) begin
                    res.status = ST_FULL;
                end else if (first > seq_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int unsigned i = seq_len; i > first; i--)
                        seq_mem[i] = seq_mem[i - 1];
                    seq_mem[first] = req.operand_value;
                    seq_len++;
                end
            end
            REQ_DEL: begin
                if (seq_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (first >= seq_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int unsigned i = first; i + 1 < seq_len; i++)
                        seq_mem[i] = seq_mem[i + 1];
                    seq_len--;
                end
            end
            default: ;
        endcase
        res.length = seq_len[10:0];
    endtask

    // drive one request and hold it until the block takes it; valid stays up after
    // the transfer so the next item can follow, an idle gap drops it first
    task automatic send_request(input logic [2:0] kind, input int unsigned first,
                                input int unsigned last, input logic [31:0] opv);
        t_in req;
        t_out res;
        req.req_type = kind;
        req.first_pos = first[10:0];
        req.last_pos = last[9:0];
        req.operand_value = opv;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // transfer happened at this edge
        apply_request(req, res);
        pending_results.push_back(res);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'(int'($urandom_range(20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    // sometimes reach past the end, mostly stay inside the stored sequence
    function automatic int unsigned rand_pos();
        if ($urandom_range(9) == 0) return $urandom_range(1023);
        if (seq_len == 0) return 0;
        return $urandom_range(seq_len - 1);
    endfunction

    task automatic send_random_request();
        int unsigned a;
        int unsigned b;
        int unsigned pick;
        pick = $urandom_range(99);
        a = rand_pos();
        b = rand_pos();
        if (a > b && $urandom_range(3) != 0) begin
            pick = a; a = b; b = pick;
            pick = $urandom_range(99);
        end
        if (pick < 25)
            send_request(REQ_INS, (seq_len > 0 && $urandom_range(15) != 0) ?
                         $urandom_range(seq_len) : $urandom_range(2047), 0, rand_word());
        else if (pick < 37) send_request(REQ_DEL, $urandom_range(9) == 0 ?
                                         $urandom_range(2047) : a, 0, rand_word());
        else if (pick < 52) send_request(REQ_ADD, a, b, rand_word());
        else if (pick < 72) send_request(REQ_MIN, a, b, rand_word());
        else if (pick < 83) send_request(REQ_REV, a, b, rand_word());
        else if (pick < 98) send_request(REQ_ROT, a, b, $urandom_range(3) == 0 ?
                                         rand_word() : $urandom_range(40));
        else send_request(3'($urandom_range(7, 6)), a, b, rand_word());
    endtask

    // receiver side: random stall, check each transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(o_data.length), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_data.min_value !== want.min_value)
                        report_mismatch("min_value", o_data.min_value, want.min_value);
                    if (o_data.status !== want.status)
                        report_mismatch("status", 32'(o_data.status), 32'(want.status));
                    if (o_data.length !== want.length)
                        report_mismatch("length", 32'(o_data.length), 32'(want.length));
                end
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // empty store: delete, min, add and out-of-range inserts must flag or do nothing
    task automatic test_empty_store();
        send_request(REQ_DEL, 0, 0, 0);
        send_request(REQ_MIN, 0, 0, 0);
        send_request(REQ_ADD, 0, 0, 5);
        send_request(REQ_ADD, 3, 1, 5);
        send_request(REQ_INS, 1, 0, 7);
        send_request(REQ_INS, 2047, 0, 7);
    endtask

    // small sequence through each request kind and its corners
    task automatic test_basic_requests();
        send_request(REQ_INS, 0, 0, 32'h7fff_ffff);
        send_request(REQ_INS, 1, 0, 32'h8000_0000);
        send_request(REQ_INS, 1, 0, 32'hffff_ffff);
        send_request(REQ_INS, 3, 0, 32'd12);
        send_request(REQ_INS, 0, 1023, 32'd3);
        send_request(REQ_ADD, 0, 4, 32'd1);
        send_request(REQ_MIN, 0, 4, 0);
        send_request(REQ_MIN, 4, 2, 0);
        send_request(REQ_MIN, 0, 1023, 0);
        send_request(REQ_REV, 0, 4, 0);
        send_request(REQ_REV, 2, 1, 0);
        send_request(REQ_ROT, 0, 4, 32'd7);
        send_request(REQ_ROT, 1, 3, 32'h8000_0000);
        send_request(REQ_ROT, 2, 2, 32'd1);
        send_request(REQ_ROT, 0, 4, 32'd5);
        send_request(REQ_ROT, 0, 1023, 32'd1);
        send_request(3'd6, 2047, 1023, 32'hffff_ffff);
        send_request(3'd7, 0, 0, 0);
        send_request(REQ_MIN, 0, 4, 0);
        send_request(REQ_DEL, 4, 0, 0);
        send_request(REQ_DEL, 4, 0, 0);
        send_request(REQ_DEL, 0, 0, 0);
    endtask

    // grow a longer sequence, then whole-range min, add, reverse and rotate, an inner rotate, then trim
    task automatic test_long_sequence();
        while (seq_len < 48) send_request(REQ_INS, $urandom_range(seq_len), 0, rand_word());
        send_request(REQ_MIN, 0, seq_len - 1, 0);
        send_request(REQ_ADD, 0, seq_len - 1, 32'h7fff_ffff);
        send_request(REQ_REV, 0, seq_len - 1, 0);
        send_request(REQ_ROT, 0, seq_len - 1, 32'd29);
        send_request(REQ_ROT, 3, seq_len - 2, 32'h7fff_ffff);
        send_request(REQ_MIN, 0, seq_len - 1, 0);
        while (seq_len > 40) send_request(REQ_DEL, seq_len - 1, 0, 0);
    endtask

    task automatic test_random_phase(input int snd, input int rcv, input int count);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        repeat (count) send_random_request();
    endtask

    initial begin
        int guard;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        seq_len = 0;
        err_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 19;
        recv_idle_pct = 83;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_basic_requests();
        test_long_sequence();
        test_random_phase(19, 83, 70);
        test_random_phase(83, 19, 70);
        test_random_phase(0, 0, 60);
        i_valid <= 1'b0;

        // drain, then let the block settle
        guard = 0;
        while (pending_results.size() != 0 && guard < 4 * STALL_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/sre_pkg.sv
rtl/sre_ram.sv
rtl/sre_mod.sv
rtl/sequence_range_update_engine_top.sv
rtl/sre_checker.sv
dv/tb_sequence_range_update_engine_top.sv
